>>> src/cdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared widths, register indexes and the queued item type of the
// central-difference gradient block.
// ----------------------------------------------------------------------------
package cdg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 9;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam int LS_DEPTH = MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int LS_W     = 2 * PIX_W;

  // queue depth, power of two
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 11'd480;
  localparam logic [CFG_W-1:0] FRAME_COLS_RST = 11'd640;

  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [LS_AW-1:0]   addr;
    logic [COORD_W-1:0] orow;
    logic [COORD_W-1:0] ocol;
    logic               emit;
    logic               border;
  } cdg_item_t;

endpackage
`default_nettype wire

>>> src/cdg_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_pix_if
// Pixel input channel: valid/ready with one grayscale pixel per item.
// ----------------------------------------------------------------------------
interface cdg_pix_if;
  logic                        valid;
  logic                        ready;
  logic [cdg_pkg::PIX_W-1:0]   pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

>>> src/cdg_grad_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_grad_if
// Gradient result channel: valid/ready with gradients and pixel position.
// ----------------------------------------------------------------------------
interface cdg_grad_if;
  logic                               valid;
  logic                               ready;
  logic signed [cdg_pkg::GRAD_W-1:0]  grad_x;
  logic signed [cdg_pkg::GRAD_W-1:0]  grad_y;
  logic [cdg_pkg::COORD_W-1:0]        out_row;
  logic [cdg_pkg::COORD_W-1:0]        out_col;

  modport source (output valid, output grad_x, output grad_y, output out_row,
                  output out_col, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input out_row,
                  input out_col, output ready);
endinterface
`default_nettype wire

>>> src/centered_difference_gradient.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centered_difference_gradient
// 3x3 central-difference gradient over a raster pixel stream.
// Path: an accepted pixel passes the item queue, the line store read stage
// and the output register. Throughput: one pixel per cycle while the output
// is not stalled; the line store has one read and one write port, each used
// once per pixel. Reset: the 1024-entry line store is cleared one column per
// cycle, and no pixel is accepted until it is cleared; configuration writes
// are taken during that time. Frame size resets to 480 rows by 640 columns.
// ----------------------------------------------------------------------------
module centered_difference_gradient (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cdg_pix_if.sink                            in_pix,
  cdg_grad_if.source                         out_grad,
  input  wire logic                          cfg_we,
  input  wire logic [cdg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cdg_pkg::CFG_W-1:0]     cfg_data
);
  import cdg_pkg::*;

  logic      init_busy;
  logic      push_valid, push_ready;
  cdg_item_t push_item;
  logic      pop_valid, pop;
  cdg_item_t pop_item;

  cdg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_pix     (in_pix),
    .init_busy  (init_busy),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  cdg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop)
  );

  cdg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .init_busy (init_busy),
    .out_grad  (out_grad)
  );

endmodule
`default_nettype wire

>>> src/cdg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module cdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/cdg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_front
// Frame size registers and raster position tracking; tags each pixel with
// its line store address, output position, emit and border flags.
// ----------------------------------------------------------------------------
module cdg_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [cdg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cdg_pkg::CFG_W-1:0]   cfg_data,
  cdg_pix_if.sink                          in_pix,
  input  wire logic                        init_busy,
  input  wire logic                        push_ready,
  output logic                             push_valid,
  output cdg_pkg::cdg_item_t               push_item
);
  import cdg_pkg::*;

  logic [CFG_W-1:0]   rows_cfg_r, rows_cfg_nxt;
  logic [CFG_W-1:0]   cols_cfg_r, cols_cfg_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;

  logic [CFG_W-1:0]   rows_eff, cols_eff;
  logic [COORD_W-1:0] r, c;
  logic [CFG_W-1:0]   r_inc, c_inc;
  logic [COORD_W-1:0] orow, ocol;
  logic               accept;

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ROWS: rows_cfg_nxt = cfg_data;
        REG_FRAME_COLS: cols_cfg_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = CFG_W'(1);
    end else if (rows_cfg_r > CFG_W'(MAX_HEIGHT)) begin
      rows_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      rows_eff = rows_cfg_r;
    end
    if (cols_cfg_r == '0) begin
      cols_eff = CFG_W'(1);
    end else if (cols_cfg_r > CFG_W'(MAX_WIDTH)) begin
      cols_eff = CFG_W'(MAX_WIDTH);
    end else begin
      cols_eff = cols_cfg_r;
    end
  end

  assign accept       = in_pix.valid && in_pix.ready;
  assign in_pix.ready = push_ready && !init_busy;

  always_comb begin
    r     = ({1'b0, row_r} >= rows_eff) ? '0 : row_r;
    c     = ({1'b0, col_r} >= cols_eff) ? '0 : col_r;
    r_inc = {1'b0, r} + CFG_W'(1);
    c_inc = {1'b0, c} + CFG_W'(1);
    orow  = r - COORD_W'(1);
    ocol  = c - COORD_W'(1);

    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (c_inc >= cols_eff) begin
        col_nxt = '0;
        row_nxt = (r_inc >= rows_eff) ? '0 : r_inc[COORD_W-1:0];
      end else begin
        col_nxt = c_inc[COORD_W-1:0];
        row_nxt = r;
      end
    end

    push_valid       = accept;
    push_item.px     = in_pix.pixel;
    push_item.addr   = c[LS_AW-1:0];
    push_item.orow   = orow;
    push_item.ocol   = ocol;
    push_item.emit   = (r != '0) && (c != '0);
    push_item.border = (orow == '0) || ({1'b0, orow} == rows_eff - CFG_W'(1)) ||
                       (ocol == '0) || ({1'b0, ocol} == cols_eff - CFG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= FRAME_ROWS_RST;
      cols_cfg_r <= FRAME_COLS_RST;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/cdg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_fifo
// Short item queue between the classifying front and the compute back.
// ----------------------------------------------------------------------------
module cdg_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire cdg_pkg::cdg_item_t push_item,
  output logic                    push_ready,
  output logic                    pop_valid,
  output cdg_pkg::cdg_item_t      pop_item,
  input  wire logic               pop
);
  import cdg_pkg::*;

  cdg_item_t            buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (cnt_r != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = buf_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (FIFO_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/cdg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_back
// Line store, 3x3 window and gradient stage with output register.
// Clears the line store after reset, one column per cycle.
// ----------------------------------------------------------------------------
module cdg_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pop_valid,
  input  wire cdg_pkg::cdg_item_t pop_item,
  output logic                    pop,
  output logic                    init_busy,
  cdg_grad_if.source              out_grad
);
  import cdg_pkg::*;

  logic                clr_busy_r, clr_busy_nxt;
  logic [LS_AW-1:0]    clr_addr_r, clr_addr_nxt;

  logic                a_valid_r, a_valid_nxt;
  cdg_item_t           a_item_r;
  logic                a_fwd_r;
  logic [LS_W-1:0]     a_fwd_data_r;

  logic [PIX_W-1:0]    win_r [3][3];

  logic                out_valid_r, out_valid_nxt;
  logic [GRAD_W-1:0]   gx_r, gy_r;
  logic [COORD_W-1:0]  orow_r, ocol_r;

  logic                out_free, a_go, a_load;
  logic                ram_we;
  logic [LS_AW-1:0]    ram_waddr;
  logic [LS_W-1:0]     ram_wdata, ram_rdata, store;
  logic [PIX_W-1:0]    col_in [3];
  logic [GRAD_W-1:0]   gx, gy;

  cdg_ram #(
    .WIDTH (LS_W),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (a_load),
    .raddr (pop_item.addr),
    .rdata (ram_rdata)
  );

  assign init_busy = clr_busy_r;
  assign out_free  = !out_valid_r || out_grad.ready;
  assign a_go      = a_valid_r && (!a_item_r.emit || out_free);
  assign a_load    = pop_valid && !clr_busy_r && (!a_valid_r || a_go);
  assign pop       = a_load;

  // [PIX_W-1:0] older row, upper half newer row
  assign store     = a_fwd_r ? a_fwd_data_r : ram_rdata;
  assign col_in[0] = store[PIX_W-1:0];
  assign col_in[1] = store[LS_W-1:PIX_W];
  assign col_in[2] = a_item_r.px;

  assign ram_we    = clr_busy_r || a_go;
  assign ram_waddr = clr_busy_r ? clr_addr_r : a_item_r.addr;
  assign ram_wdata = clr_busy_r ? '0 : {a_item_r.px, col_in[1]};

  assign gx = {1'b0, col_in[1]} - {1'b0, win_r[1][1]};
  assign gy = {1'b0, win_r[2][2]} - {1'b0, win_r[0][2]};

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + LS_AW'(1);
      if (clr_addr_r == LS_AW'(LS_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    a_valid_nxt = a_load ? 1'b1 : (a_go ? 1'b0 : a_valid_r);
    if (a_go && a_item_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_grad.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // read and write of the same column in one cycle: take the written value
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item_r     <= pop_item;
      a_fwd_r      <= a_go && (a_item_r.addr == pop_item.addr);
      a_fwd_data_r <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          win_r[y][x] <= '0;
        end
      end
    end else if (a_go) begin
      for (int y = 0; y < 3; y++) begin
        win_r[y][0] <= win_r[y][1];
        win_r[y][1] <= win_r[y][2];
        win_r[y][2] <= col_in[y];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_item_r.emit) begin
      gx_r   <= a_item_r.border ? '0 : gx;
      gy_r   <= a_item_r.border ? '0 : gy;
      orow_r <= a_item_r.orow;
      ocol_r <= a_item_r.ocol;
    end
  end

  assign out_grad.valid   = out_valid_r;
  assign out_grad.grad_x  = gx_r;
  assign out_grad.grad_y  = gy_r;
  assign out_grad.out_row = orow_r;
  assign out_grad.out_col = ocol_r;

endmodule
`default_nettype wire
